// File: src/mouse_report_builder_defines.svh
// Assertion macros shared by the mouse report builder RTL.
`ifndef MOUSE_REPORT_BUILDER_DEFINES_SVH
`define MOUSE_REPORT_BUILDER_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define MRB_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define MRB_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/mrb_pkg.sv
// Shared types, constants and functions of the mouse report builder.
`default_nettype none

package mrb_pkg;

	localparam int NUM_BUTTONS_DEF = 4;
	localparam int RES_LEVELS_DEF  = 6;
	localparam int TIME_BITS_DEF   = 32;

	localparam int NOW_W      = 32;
	localparam int RAW_W      = 16;
	localparam int BTN_W      = 4;
	localparam int MOVE_W     = 8;
	localparam int WHEEL_W    = 2;
	localparam int CPI_W      = 8;
	localparam int POLL_W     = 8;
	localparam int RES_IDX_W  = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int DEBOUNCE_W = 8;
	localparam int SCROLL_W   = 16;
	localparam int IDLE_W     = 32;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST     = 8'd8;
	localparam logic [SCROLL_W-1:0]   SCROLL_DELAY_RST  = 16'd250;
	localparam logic [SCROLL_W-1:0]   SCROLL_REPEAT_RST = 16'd25;
	localparam logic [IDLE_W-1:0]     IDLE_RST          = 32'd10000;
	localparam logic [IDLE_W-1:0]     SLEEP_RST         = 32'd240000;
	localparam logic [POLL_W-1:0]     SLOW_POLL_RST     = 8'd25;
	localparam logic [POLL_W-1:0]     FAST_POLL         = 8'd1;
	localparam logic [RES_IDX_W-1:0]  RES_IDX_RST       = 3'd4;

	localparam logic signed [RAW_W-1:0]   RAW_SAT_HI  = 16'sd127;
	localparam logic signed [RAW_W-1:0]   RAW_SAT_LO  = -16'sd127;
	localparam logic signed [MOVE_W-1:0]  MOVE_HI     = 8'sd127;
	localparam logic signed [MOVE_W-1:0]  MOVE_LO     = -8'sd127;
	localparam logic signed [MOVE_W-1:0]  MOVE_BAD    = 8'sh80;
	localparam logic signed [WHEEL_W-1:0] WHEEL_UP    = 2'sd1;
	localparam logic signed [WHEEL_W-1:0] WHEEL_DOWN  = -2'sd1;
	localparam logic signed [WHEEL_W-1:0] WHEEL_NONE  = 2'sd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE      = 3'd0,
		REG_SCROLL_DELAY  = 3'd1,
		REG_SCROLL_REPEAT = 3'd2,
		REG_IDLE          = 3'd3,
		REG_SLEEP         = 3'd4,
		REG_SLOW_POLL     = 3'd5
	} cfg_reg_t;

	function automatic logic [CPI_W-1:0] cpi_lookup(input logic [RES_IDX_W-1:0] idx);
		logic [CPI_W-1:0] val;
		case (idx)
			3'd0: val = 8'd4;
			3'd1: val = 8'd8;
			3'd2: val = 8'd16;
			3'd3: val = 8'd32;
			3'd4: val = 8'd48;
			default: val = 8'd64;
		endcase
		return val;
	endfunction

	function automatic logic signed [MOVE_W-1:0] sat_move(input logic signed [RAW_W-1:0] v);
		logic signed [MOVE_W-1:0] res;
		if (v > RAW_SAT_HI) begin
			res = MOVE_HI;
		end else if (v < RAW_SAT_LO) begin
			res = MOVE_LO;
		end else begin
			res = v[MOVE_W-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// File: src/mrb_if.sv
// Channel interfaces of the mouse report builder: poll items, reports and register writes.
`default_nettype none

interface mrb_item_if;
	import mrb_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [NOW_W-1:0]        now_ms;
	logic                    motion_valid;
	logic signed [RAW_W-1:0] raw_dx;
	logic signed [RAW_W-1:0] raw_dy;
	logic [BTN_W-1:0]        button_levels;
	logic                    res_button;
	logic                    touch_up;
	logic                    touch_down;

	modport source (
		output valid, now_ms, motion_valid, raw_dx, raw_dy, button_levels,
			res_button, touch_up, touch_down,
		input ready
	);
	modport sink (
		input valid, now_ms, motion_valid, raw_dx, raw_dy, button_levels,
			res_button, touch_up, touch_down,
		output ready
	);
endinterface

interface mrb_result_if;
	import mrb_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      send;
	logic [BTN_W-1:0]          buttons;
	logic signed [MOVE_W-1:0]  move_x;
	logic signed [MOVE_W-1:0]  move_y;
	logic signed [WHEEL_W-1:0] wheel;
	logic                      cpi_write;
	logic [CPI_W-1:0]          cpi_value;
	logic [POLL_W-1:0]         poll_period;
	logic                      power_off;

	modport source (
		output valid, send, buttons, move_x, move_y, wheel, cpi_write, cpi_value,
			poll_period, power_off,
		input ready
	);
	modport sink (
		input valid, send, buttons, move_x, move_y, wheel, cpi_write, cpi_value,
			poll_period, power_off,
		output ready
	);
endinterface

interface mrb_cfg_if;
	import mrb_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/mouse_report_builder.sv
// Mouse report builder: debounce, motion saturation, resolution stepping, scroll and idle tracking.
// An accepted poll item is registered in the input stage and evaluated in one pass; its report is
// registered in the result stage once that stage is empty or being read by the receiver.
// One item per cycle is sustained while result.ready stays high; the state update of each item
// lands as its report is stored. Asynchronous reset restores all state and registers to their
// reset values and empties both stages; register writes are always taken.
`default_nettype none

module mouse_report_builder #(
	parameter int NUM_BUTTONS = mrb_pkg::NUM_BUTTONS_DEF,
	parameter int RES_LEVELS  = mrb_pkg::RES_LEVELS_DEF,
	parameter int TIME_BITS   = mrb_pkg::TIME_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mrb_item_if.sink     item,
	mrb_result_if.source result,
	mrb_cfg_if.sink      cfg
);
	import mrb_pkg::*;

	`include "mouse_report_builder_defines.svh"

	localparam int CMP_W = (TIME_BITS > IDLE_W) ? TIME_BITS : IDLE_W;

	// Registers.
	logic [DEBOUNCE_W-1:0] debounce_q;
	logic [SCROLL_W-1:0]   scroll_delay_q;
	logic [SCROLL_W-1:0]   scroll_repeat_q;
	logic [IDLE_W-1:0]     idle_q;
	logic [IDLE_W-1:0]     sleep_q;
	logic [POLL_W-1:0]     slow_poll_q;

	// Input stage.
	logic                    valid_s1;
	logic [TIME_BITS-1:0]    now_s1;
	logic                    motion_s1;
	logic signed [RAW_W-1:0] dx_s1;
	logic signed [RAW_W-1:0] dy_s1;
	logic [BTN_W-1:0]        levels_s1;
	logic                    res_btn_s1;
	logic [1:0]              touch_s1;

	// Result stage.
	logic                      valid_s2;
	logic                      send_s2;
	logic [BTN_W-1:0]          buttons_s2;
	logic signed [MOVE_W-1:0]  move_x_s2;
	logic signed [MOVE_W-1:0]  move_y_s2;
	logic signed [WHEEL_W-1:0] wheel_s2;
	logic                      cpi_write_s2;
	logic [CPI_W-1:0]          cpi_value_s2;
	logic [POLL_W-1:0]         poll_s2;
	logic                      power_off_s2;

	// Block state.
	logic [NUM_BUTTONS-1:0] btn_q;
	logic [TIME_BITS-1:0]   btn_time_q [NUM_BUTTONS];
	logic                   res_held_q;
	logic [RES_IDX_W-1:0]   res_idx_q;
	logic [1:0]             pad_active_q;
	logic [TIME_BITS-1:0]   pad_hold_q [2];
	logic [TIME_BITS-1:0]   pad_last_q [2];
	logic [TIME_BITS-1:0]   last_report_q;
	logic                   slow_q;

	// Next-state and result logic.
	logic                      adv;
	logic [NUM_BUTTONS-1:0]    btn_chg;
	logic [NUM_BUTTONS-1:0]    btn_d;
	logic [BTN_W-1:0]          mask;
	logic [RES_IDX_W:0]        res_nx;
	logic                      res_step;
	logic [RES_IDX_W-1:0]      res_idx_d;
	logic [1:0]                pad_step;
	logic signed [WHEEL_W-1:0] wheel_c;
	logic                      changed;
	logic [TIME_BITS-1:0]      since_report;
	logic                      sleep_hit;
	logic                      idle_hit;
	logic                      slow_d;
	logic [POLL_W-1:0]         poll_c;
	logic signed [MOVE_W-1:0]  move_x_c;
	logic signed [MOVE_W-1:0]  move_y_c;

	assign adv        = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q      <= DEBOUNCE_RST;
			scroll_delay_q  <= SCROLL_DELAY_RST;
			scroll_repeat_q <= SCROLL_REPEAT_RST;
			idle_q          <= IDLE_RST;
			sleep_q         <= SLEEP_RST;
			slow_poll_q     <= SLOW_POLL_RST;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_DEBOUNCE:      debounce_q      <= cfg.data[DEBOUNCE_W-1:0];
				REG_SCROLL_DELAY:  scroll_delay_q  <= cfg.data[SCROLL_W-1:0];
				REG_SCROLL_REPEAT: scroll_repeat_q <= cfg.data[SCROLL_W-1:0];
				REG_IDLE:          idle_q          <= cfg.data[IDLE_W-1:0];
				REG_SLEEP:         sleep_q         <= cfg.data[IDLE_W-1:0];
				REG_SLOW_POLL:     slow_poll_q     <= cfg.data[POLL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			now_s1     <= TIME_BITS'(item.now_ms);
			motion_s1  <= item.motion_valid;
			dx_s1      <= item.raw_dx;
			dy_s1      <= item.raw_dy;
			levels_s1  <= item.button_levels;
			res_btn_s1 <= item.res_button;
			touch_s1   <= {item.touch_down, item.touch_up};
		end
	end

	for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
		logic                 lvl;
		logic [TIME_BITS-1:0] held;
		if (g < BTN_W) begin : g_lvl
			assign lvl = levels_s1[g];
		end else begin : g_none
			assign lvl = 1'b0;
		end
		assign held       = now_s1 - btn_time_q[g];
		assign btn_chg[g] = (lvl != btn_q[g]) && (held >= TIME_BITS'(debounce_q));
		assign btn_d[g]   = btn_chg[g] ? lvl : btn_q[g];
	end

	for (genvar b = 0; b < BTN_W; b++) begin : g_mask
		if (b < NUM_BUTTONS) begin : g_used
			assign mask[b] = btn_d[b];
		end else begin : g_unused
			assign mask[b] = 1'b0;
		end
	end

	for (genvar p = 0; p < 2; p++) begin : g_pad
		logic [TIME_BITS-1:0] hold_el;
		logic [TIME_BITS-1:0] last_el;
		assign hold_el     = now_s1 - pad_hold_q[p];
		assign last_el     = now_s1 - pad_last_q[p];
		assign pad_step[p] = touch_s1[p] && (!pad_active_q[p] ||
			(hold_el >= TIME_BITS'(scroll_delay_q) && last_el >= TIME_BITS'(scroll_repeat_q)));
	end

	always_comb begin
		res_nx    = {1'b0, res_idx_q} + 1'b1;
		res_step  = res_btn_s1 && !res_held_q;
		res_idx_d = res_idx_q;
		if (res_step) begin
			res_idx_d = (res_nx >= (RES_IDX_W + 1)'(RES_LEVELS)) ? '0 : res_nx[RES_IDX_W-1:0];
		end

		if (&touch_s1) begin
			wheel_c = WHEEL_NONE;
		end else if (pad_step[1]) begin
			wheel_c = WHEEL_DOWN;
		end else if (pad_step[0]) begin
			wheel_c = WHEEL_UP;
		end else begin
			wheel_c = WHEEL_NONE;
		end

		move_x_c = motion_s1 ? -sat_move(dx_s1) : '0;
		move_y_c = motion_s1 ? sat_move(dy_s1) : '0;

		changed      = motion_s1 || (|btn_chg) || (|pad_step) || (&touch_s1);
		since_report = changed ? '0 : now_s1 - last_report_q;
		sleep_hit    = CMP_W'(since_report) >= CMP_W'(sleep_q);
		idle_hit     = CMP_W'(since_report) >= CMP_W'(idle_q);
		slow_d       = (slow_q && !motion_s1) || (!sleep_hit && idle_hit);

		poll_c = FAST_POLL;
		if (slow_d && slow_poll_q != '0) begin
			poll_c = slow_poll_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btn_q         <= '0;
			btn_time_q    <= '{default: '0};
			res_held_q    <= 1'b0;
			res_idx_q     <= RES_IDX_RST;
			pad_active_q  <= '0;
			pad_hold_q    <= '{default: '0};
			pad_last_q    <= '{default: '0};
			last_report_q <= '0;
			slow_q        <= 1'b0;
		end else if (adv) begin
			btn_q <= btn_d;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				if (btn_chg[i]) begin
					btn_time_q[i] <= now_s1;
				end
			end
			res_held_q <= res_btn_s1;
			res_idx_q  <= res_idx_d;
			for (int p = 0; p < 2; p++) begin
				if (touch_s1[p]) begin
					if (pad_step[p]) begin
						pad_active_q[p] <= 1'b1;
						pad_last_q[p]   <= now_s1;
					end
				end else begin
					pad_active_q[p] <= 1'b0;
					pad_hold_q[p]   <= now_s1;
				end
			end
			if (changed) begin
				last_report_q <= now_s1;
			end
			slow_q <= slow_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			send_s2      <= changed;
			buttons_s2   <= mask;
			move_x_s2    <= move_x_c;
			move_y_s2    <= move_y_c;
			wheel_s2     <= wheel_c;
			cpi_write_s2 <= res_step;
			cpi_value_s2 <= cpi_lookup(res_idx_d);
			poll_s2      <= poll_c;
			power_off_s2 <= sleep_hit;
		end
	end

	assign result.valid       = valid_s2;
	assign result.send        = send_s2;
	assign result.buttons     = buttons_s2;
	assign result.move_x      = move_x_s2;
	assign result.move_y      = move_y_s2;
	assign result.wheel       = wheel_s2;
	assign result.cpi_write   = cpi_write_s2;
	assign result.cpi_value   = cpi_value_s2;
	assign result.poll_period = poll_s2;
	assign result.power_off   = power_off_s2;

	`MRB_ASSERT(a_cpi_held, clk, arst_n, adv && res_step |=> res_held_q && cpi_write_s2, "Resolution step did not mark the button as held.")
	`MRB_ASSERT(a_quiet_report, clk, arst_n, valid_s2 && !send_s2 |-> wheel_s2 == WHEEL_NONE && move_x_s2 == '0 && move_y_s2 == '0, "Motion or scroll reported without a send.")
	`MRB_ASSERT(a_move_sat, clk, arst_n, valid_s2 |-> move_x_s2 != MOVE_BAD && move_y_s2 != MOVE_BAD, "Motion left the saturation range.")
	`MRB_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !valid_s1 && !valid_s2, "A stage holds a transaction during reset.")

endmodule

`default_nettype wire

// File: test/mouse_report_builder_test.sv
// Self-checking testbench of the mouse report builder with its own report predictor.
`default_nettype none

module mouse_report_builder_test;
	import mrb_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam logic [8*CPI_W-1:0] CPI_STEPS =
		{8'd64, 8'd64, 8'd64, 8'd48, 8'd32, 8'd16, 8'd8, 8'd4};

	typedef struct packed {
		logic [NOW_W-1:0]        now_ms;
		logic                    motion_valid;
		logic signed [RAW_W-1:0] raw_dx;
		logic signed [RAW_W-1:0] raw_dy;
		logic [BTN_W-1:0]        button_levels;
		logic                    res_button;
		logic                    touch_up;
		logic                    touch_down;
	} poll_t;

	typedef struct packed {
		logic                      send;
		logic [BTN_W-1:0]          buttons;
		logic signed [MOVE_W-1:0]  move_x;
		logic signed [MOVE_W-1:0]  move_y;
		logic signed [WHEEL_W-1:0] wheel;
		logic                      cpi_write;
		logic [CPI_W-1:0]          cpi_value;
		logic [POLL_W-1:0]         poll_period;
		logic                      power_off;
	} report_t;

	class report_scoreboard;
		logic [7:0]  debounce;
		logic [15:0] scroll_delay;
		logic [15:0] scroll_repeat;
		logic [31:0] idle_limit;
		logic [31:0] sleep_limit;
		logic [7:0]  slow_poll;

		logic [BTN_W-1:0]  btn_down;
		logic [31:0]       btn_stamp [BTN_W];
		logic              res_held;
		logic [2:0]        res_idx;
		logic              up_active;
		logic [31:0]       up_hold;
		logic [31:0]       up_last;
		logic              dn_active;
		logic [31:0]       dn_hold;
		logic [31:0]       dn_last;
		logic [31:0]       last_report;
		logic              slow;

		report_t expected_reports [$];
		int      faults;
		int      seen;

		function new();
			debounce = DEBOUNCE_RST;
			scroll_delay = SCROLL_DELAY_RST;
			scroll_repeat = SCROLL_REPEAT_RST;
			idle_limit = IDLE_RST;
			sleep_limit = SLEEP_RST;
			slow_poll = SLOW_POLL_RST;
			btn_down = '0;
			foreach (btn_stamp[i]) btn_stamp[i] = '0;
			res_held = 1'b0;
			res_idx = RES_IDX_RST;
			up_active = 1'b0;
			up_hold = '0;
			up_last = '0;
			dn_active = 1'b0;
			dn_hold = '0;
			dn_last = '0;
			last_report = '0;
			slow = 1'b0;
			faults = 0;
			seen = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [31:0] v);
			case (idx)
				REG_DEBOUNCE: debounce = v[7:0];
				REG_SCROLL_DELAY: scroll_delay = v[15:0];
				REG_SCROLL_REPEAT: scroll_repeat = v[15:0];
				REG_IDLE: idle_limit = v;
				REG_SLEEP: sleep_limit = v;
				REG_SLOW_POLL: slow_poll = v[7:0];
				default: ;
			endcase
		endfunction

		function logic signed [MOVE_W-1:0] clip(logic signed [RAW_W-1:0] v);
			if (v > 16'sd127) return 8'sd127;
			if (v < -16'sd127) return -8'sd127;
			return v[MOVE_W-1:0];
		endfunction

		function logic pad_step(input logic touched, input logic [31:0] now,
				inout logic active, inout logic [31:0] hold_start,
				inout logic [31:0] last_step);
			if (touched) begin
				if (!active || ((now - hold_start) >= {16'b0, scroll_delay} &&
						(now - last_step) >= {16'b0, scroll_repeat})) begin
					active = 1'b1;
					last_step = now;
					return 1'b1;
				end
				return 1'b0;
			end
			hold_start = now;
			active = 1'b0;
			return 1'b0;
		endfunction

		function report_t build_report(poll_t p);
			report_t r;
			logic [31:0] now;
			logic [31:0] since;
			logic [3:0] nx;
			logic up_step;
			logic dn_step;
			r = '0;
			now = p.now_ms;
			if (p.motion_valid) begin
				r.move_x = -clip(p.raw_dx);
				r.move_y = clip(p.raw_dy);
				r.send = 1'b1;
				slow = 1'b0;
			end
			for (int i = 0; i < BTN_W; i++) begin
				if (p.button_levels[i] != btn_down[i] &&
						(now - btn_stamp[i]) >= {24'b0, debounce}) begin
					btn_down[i] = p.button_levels[i];
					btn_stamp[i] = now;
					r.send = 1'b1;
				end
			end
			r.buttons = btn_down;
			if (p.res_button) begin
				if (!res_held) begin
					nx = {1'b0, res_idx} + 4'd1;
					if (nx >= RES_LEVELS_DEF) nx = '0;
					res_idx = nx[2:0];
					r.cpi_write = 1'b1;
					res_held = 1'b1;
				end
			end else begin
				res_held = 1'b0;
			end
			up_step = pad_step(p.touch_up, now, up_active, up_hold, up_last);
			dn_step = pad_step(p.touch_down, now, dn_active, dn_hold, dn_last);
			if (up_step) begin
				r.wheel = WHEEL_UP;
				r.send = 1'b1;
			end
			if (dn_step) begin
				r.wheel = WHEEL_DOWN;
				r.send = 1'b1;
			end
			if (p.touch_up && p.touch_down) begin
				r.wheel = WHEEL_NONE;
				r.send = 1'b1;
			end
			if (r.send) last_report = now;
			since = now - last_report;
			if (since >= sleep_limit) r.power_off = 1'b1;
			else if (since >= idle_limit) slow = 1'b1;
			r.poll_period = (slow && slow_poll != '0) ? slow_poll : FAST_POLL;
			r.cpi_value = CPI_STEPS[res_idx*CPI_W +: CPI_W];
			return r;
		endfunction

		function void note_poll(poll_t p);
			expected_reports.push_back(build_report(p));
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		task flag(string msg);
			faults++;
			$display("report %0d: %s", seen, msg);
		endtask

		task check_report(report_t got);
			report_t want;
			seen++;
			if (expected_reports.size() == 0) begin
				flag($sformatf("unexpected transaction %p", got));
				return;
			end
			want = expected_reports.pop_front();
			if (got.send !== want.send)
				flag($sformatf("send %b, want %b", got.send, want.send));
			if (got.buttons !== want.buttons)
				flag($sformatf("buttons %h, want %h", got.buttons, want.buttons));
			if (got.move_x !== want.move_x)
				flag($sformatf("move_x %0d, want %0d", got.move_x, want.move_x));
			if (got.move_y !== want.move_y)
				flag($sformatf("move_y %0d, want %0d", got.move_y, want.move_y));
			if (got.wheel !== want.wheel)
				flag($sformatf("wheel %0d, want %0d", got.wheel, want.wheel));
			if (got.cpi_write !== want.cpi_write)
				flag($sformatf("cpi_write %b, want %b", got.cpi_write, want.cpi_write));
			if (got.cpi_value !== want.cpi_value)
				flag($sformatf("cpi_value %0d, want %0d", got.cpi_value, want.cpi_value));
			if (got.poll_period !== want.poll_period)
				flag($sformatf("poll_period %0d, want %0d",
					got.poll_period, want.poll_period));
			if (got.power_off !== want.power_off)
				flag($sformatf("power_off %b, want %b", got.power_off, want.power_off));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	mrb_item_if   item_ch ();
	mrb_result_if result_ch ();
	mrb_cfg_if    cfg_ch ();

	mouse_report_builder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	report_scoreboard sb;

	logic [31:0]      clock_ms;
	logic [BTN_W-1:0] held_buttons;
	logic             held_res;
	logic             held_up;
	logic             held_dn;
	int               burst_left;
	logic             squeeze;
	int               quiet;
	int               rx_mode;
	int               rx_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		report_t got;
		poll_t   taken;
		if (arst_n === 1'b1) begin
			if (result_ch.valid && result_ch.ready) begin
				got.send = result_ch.send;
				got.buttons = result_ch.buttons;
				got.move_x = result_ch.move_x;
				got.move_y = result_ch.move_y;
				got.wheel = result_ch.wheel;
				got.cpi_write = result_ch.cpi_write;
				got.cpi_value = result_ch.cpi_value;
				got.poll_period = result_ch.poll_period;
				got.power_off = result_ch.power_off;
				sb.check_report(got);
			end
			if (item_ch.valid && item_ch.ready) begin
				taken.now_ms = item_ch.now_ms;
				taken.motion_valid = item_ch.motion_valid;
				taken.raw_dx = item_ch.raw_dx;
				taken.raw_dy = item_ch.raw_dy;
				taken.button_levels = item_ch.button_levels;
				taken.res_button = item_ch.res_button;
				taken.touch_up = item_ch.touch_up;
				taken.touch_down = item_ch.touch_down;
				sb.note_poll(taken);
			end
			if (cfg_ch.valid && cfg_ch.ready)
				sb.set_reg(cfg_reg_t'(cfg_ch.index), cfg_ch.data);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet = quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("mouse_report_builder verification failed");
				$finish;
			end
		end
	end

	// The receiver switches between random stall patterns; a squeeze request
	// holds it off long enough for the block to fill and stall its input.
	initial begin
		result_ch.ready = 1'b0;
		rx_count = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (squeeze) begin
				result_ch.ready <= 1'b0;
				repeat (120) @(posedge clk);
				squeeze = 1'b0;
			end else begin
				if (rx_count == 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_count = $urandom_range(16, 96);
				end
				rx_count--;
				case (rx_mode)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= 1'($urandom_range(0, 1));
					2: result_ch.ready <= (rx_count % 4 == 0);
					default: result_ch.ready <= ($urandom_range(0, 6) != 0);
				endcase
			end
		end
	end

	task push_poll(input poll_t p);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 24);
			if (gap > 0 && !squeeze) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_ch.valid <= 1'b1;
		item_ch.now_ms <= p.now_ms;
		item_ch.motion_valid <= p.motion_valid;
		item_ch.raw_dx <= p.raw_dx;
		item_ch.raw_dy <= p.raw_dy;
		item_ch.button_levels <= p.button_levels;
		item_ch.res_button <= p.res_button;
		item_ch.touch_up <= p.touch_up;
		item_ch.touch_down <= p.touch_down;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
	endtask

	task poke(input logic [31:0] t, input logic mv, input logic signed [RAW_W-1:0] dx,
			input logic signed [RAW_W-1:0] dy, input logic [BTN_W-1:0] btn,
			input logic res, input logic up, input logic dn);
		poll_t p;
		p = '{now_ms: t, motion_valid: mv, raw_dx: dx, raw_dy: dy, button_levels: btn,
			res_button: res, touch_up: up, touch_down: dn};
		push_poll(p);
	endtask

	function automatic logic signed [RAW_W-1:0] pick_raw();
		int v;
		case ($urandom_range(0, 7))
			0: v = 32767;
			1: v = -32768;
			2: v = $urandom;
			3: v = $urandom_range(0, 255) - 128;
			default: v = $urandom_range(0, 600) - 300;
		endcase
		return v[RAW_W-1:0];
	endfunction

	// Button and pad levels persist between polls so that holds, repeats and
	// debounce windows are actually exercised; occasional bursts of noise remain.
	task roll_poll(output poll_t p);
		case ($urandom_range(0, 19))
			0: ;
			1: clock_ms = $urandom;
			2: clock_ms = clock_ms + $urandom_range(200, 20000);
			default: clock_ms = clock_ms + $urandom_range(1, 30);
		endcase
		for (int i = 0; i < BTN_W; i++)
			if ($urandom_range(0, 5) == 0) held_buttons[i] = ~held_buttons[i];
		if ($urandom_range(0, 19) == 0) held_buttons = BTN_W'($urandom);
		if ($urandom_range(0, 4) == 0) held_res = ~held_res;
		if ($urandom_range(0, 11) == 0) held_up = ~held_up;
		if ($urandom_range(0, 11) == 0) held_dn = ~held_dn;
		p.now_ms = clock_ms;
		p.motion_valid = ($urandom_range(0, 99) < 35);
		p.raw_dx = pick_raw();
		p.raw_dy = pick_raw();
		p.button_levels = held_buttons;
		p.res_button = held_res;
		p.touch_up = held_up;
		p.touch_down = held_dn;
	endtask

	task run_phase(input int count);
		poll_t p;
		repeat (count) begin
			roll_poll(p);
			push_poll(p);
		end
	endtask

	task settle();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	task configure(input logic [7:0] db, input logic [15:0] sd, input logic [15:0] sr,
			input logic [31:0] il, input logic [31:0] sl, input logic [7:0] sp);
		write_reg(REG_DEBOUNCE, {24'b0, db});
		write_reg(REG_SCROLL_DELAY, {16'b0, sd});
		write_reg(REG_SCROLL_REPEAT, {16'b0, sr});
		write_reg(REG_IDLE, il);
		write_reg(REG_SLEEP, sl);
		write_reg(REG_SLOW_POLL, {24'b0, sp});
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		quiet = 0;
		burst_left = 0;
		squeeze = 1'b0;
		held_buttons = '0;
		held_res = 1'b0;
		held_up = 1'b0;
		held_dn = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.now_ms = '0;
		item_ch.motion_valid = 1'b0;
		item_ch.raw_dx = '0;
		item_ch.raw_dy = '0;
		item_ch.button_levels = '0;
		item_ch.res_button = 1'b0;
		item_ch.touch_up = 1'b0;
		item_ch.touch_down = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_DEBOUNCE;
		cfg_ch.data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Motion saturation at both ends, then debounce, resolution wrap and scroll.
		poke(32'd0, 1'b0, 16'sd0, 16'sd0, 4'h0, 1'b0, 1'b0, 1'b0);
		poke(32'd100, 1'b1, 16'sh7FFF, 16'sh8000, 4'h0, 1'b0, 1'b0, 1'b0);
		poke(32'd101, 1'b1, 16'sh8000, 16'sh7FFF, 4'h0, 1'b0, 1'b0, 1'b0);
		poke(32'd102, 1'b1, 16'sd128, -16'sd128, 4'h0, 1'b0, 1'b0, 1'b0);
		poke(32'd103, 1'b1, -16'sd127, 16'sd127, 4'h0, 1'b0, 1'b0, 1'b0);
		poke(32'd200, 1'b0, 16'sd0, 16'sd0, 4'hF, 1'b0, 1'b0, 1'b0);
		poke(32'd203, 1'b0, 16'sd0, 16'sd0, 4'h0, 1'b0, 1'b0, 1'b0);
		poke(32'd210, 1'b0, 16'sd0, 16'sd0, 4'h0, 1'b0, 1'b0, 1'b0);
		poke(32'd220, 1'b0, 16'sd0, 16'sd0, 4'h0, 1'b1, 1'b0, 1'b0);
		poke(32'd221, 1'b0, 16'sd0, 16'sd0, 4'h0, 1'b1, 1'b0, 1'b0);
		poke(32'd222, 1'b0, 16'sd0, 16'sd0, 4'h0, 1'b0, 1'b0, 1'b0);
		poke(32'd223, 1'b0, 16'sd0, 16'sd0, 4'h0, 1'b1, 1'b0, 1'b0);
		poke(32'd300, 1'b0, 16'sd0, 16'sd0, 4'h0, 1'b0, 1'b1, 1'b0);
		poke(32'd310, 1'b0, 16'sd0, 16'sd0, 4'h0, 1'b0, 1'b1, 1'b0);
		poke(32'd560, 1'b0, 16'sd0, 16'sd0, 4'h0, 1'b0, 1'b1, 1'b0);
		poke(32'd590, 1'b0, 16'sd0, 16'sd0, 4'h0, 1'b0, 1'b1, 1'b0);
		poke(32'd600, 1'b0, 16'sd0, 16'sd0, 4'h0, 1'b0, 1'b1, 1'b1);
		poke(32'd610, 1'b0, 16'sd0, 16'sd0, 4'h0, 1'b0, 1'b1, 1'b1);
		poke(32'd620, 1'b0, 16'sd0, 16'sd0, 4'h0, 1'b0, 1'b0, 1'b1);
		// Idle into slow polling, a button report that keeps it, motion that ends it.
		poke(32'd20000, 1'b0, 16'sd0, 16'sd0, 4'h0, 1'b0, 1'b0, 1'b0);
		poke(32'd20020, 1'b0, 16'sd0, 16'sd0, 4'h1, 1'b0, 1'b0, 1'b0);
		poke(32'd20030, 1'b1, 16'sd0, 16'sd0, 4'h1, 1'b0, 1'b0, 1'b0);
		poke(32'd260030, 1'b0, 16'sd0, 16'sd0, 4'h1, 1'b0, 1'b0, 1'b0);
		poke(32'd260031, 1'b0, 16'sd0, 16'sd0, 4'h1, 1'b0, 1'b0, 1'b0);
		poke(32'd260040, 1'b1, 16'sd1, -16'sd1, 4'h1, 1'b0, 1'b0, 1'b0);
		poke(32'hFFFF_FFF0, 1'b0, 16'sd0, 16'sd0, 4'h1, 1'b0, 1'b0, 1'b0);
		poke(32'hFFFF_FFFA, 1'b1, -16'sd1, 16'sd1, 4'h0, 1'b0, 1'b0, 1'b0);
		poke(32'h0000_0005, 1'b0, 16'sd0, 16'sd0, 4'h0, 1'b0, 1'b1, 1'b0);
		clock_ms = 32'd5;

		run_phase(150);
		squeeze = 1'b1;
		run_phase(150);
		settle();

		configure(8'd0, 16'd0, 16'd0, 32'd0, 32'hFFFF_FFFF, 8'd0);
		run_phase(200);
		settle();

		configure(8'd255, 16'd65535, 16'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
		run_phase(200);
		settle();

		configure(8'd20, 16'd100, 16'd30, 32'd300, 32'd3000, 8'd10);
		run_phase(350);
		settle();

		configure(8'd3, 16'd40, 16'd5, 32'd5, 32'd0, 8'd1);
		run_phase(200);
		settle();

		configure(8'($urandom_range(0, 40)), 16'($urandom_range(0, 400)),
			16'($urandom_range(0, 60)), 32'($urandom_range(0, 2000)),
			32'($urandom_range(0, 20000)), 8'($urandom_range(0, 255)));
		run_phase(200);
		settle();

		repeat (4) @(posedge clk);
		if (sb.faults == 0)
			$display("mouse_report_builder verification clean");
		else
			$display("mouse_report_builder verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
+incdir+src
src/mrb_pkg.sv
src/mrb_if.sv
src/mouse_report_builder.sv
test/mouse_report_builder_test.sv
